@@ rtl/rqr_pkg.sv @@
// Shared widths, register indexes and operation codes for the residual quantizer.
package rqr_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int STEP_W         = 16;
  localparam int OFFSET_W       = 17;
  localparam int DEPTH_W        = 5;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 17;
  localparam int DIVIDEND_W     = 18;
  localparam int BITS_PER_STAGE = 3;
  localparam int DIV_STAGES     = DIVIDEND_W / BITS_PER_STAGE;
  localparam int SUM_W          = 20;
  localparam int PROD_W         = 2 * SAMPLE_W;
  localparam int REC_W          = PROD_W + 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_QUANT_STEP   = 2'd0,
    REG_QUANT_OFFSET = 2'd1,
    REG_BIT_DEPTH    = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

endpackage

@@ rtl/rqr_divider.sv @@
// Pipelined restoring divider, a few quotient bits per stage.
module rqr_divider (
  input  logic                            clk,
  input  logic [rqr_pkg::STEP_W-1:0]     divisor,
  input  logic [rqr_pkg::DIVIDEND_W-1:0] dividend,
  output logic [rqr_pkg::DIVIDEND_W-1:0] quotient
);
  import rqr_pkg::*;

  logic [STEP_W-1:0]     rem_q [DIV_STAGES];
  logic [DIVIDEND_W-1:0] num_q [DIV_STAGES];
  logic [DIVIDEND_W-1:0] quo_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [STEP_W-1:0]     rem_in;
    logic [DIVIDEND_W-1:0] num_in;
    logic [DIVIDEND_W-1:0] quo_in;
    logic [STEP_W-1:0]     rem_next;
    logic [DIVIDEND_W-1:0] num_next;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [STEP_W:0]       trial;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = dividend;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[s-1];
      assign num_in = num_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      rem_next = rem_in;
      num_next = num_in;
      quo_next = quo_in;
      trial    = '0;
      for (int i = 0; i < BITS_PER_STAGE; i++) begin
        trial    = {rem_next, num_next[DIVIDEND_W-1]};
        num_next = {num_next[DIVIDEND_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem_next = STEP_W'(trial - {1'b0, divisor});
          quo_next = {quo_next[DIVIDEND_W-2:0], 1'b1};
        end else begin
          rem_next = trial[STEP_W-1:0];
          quo_next = {quo_next[DIVIDEND_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_q[s] <= rem_next;
      num_q[s] <= num_next;
      quo_q[s] <= quo_next;
    end
  end

  assign quotient = quo_q[DIV_STAGES-1];

endmodule

@@ rtl/residual_quantize_reconstruct.sv @@
// Residual quantizer and reconstructor, top level.
// A request accepted by the input stage passes through stage s1, the divider stages, the
// select stage and the dequantize stage to the output registers; done is high for one cycle.
// Throughput: one request per cycle; busy is tied low and the 6-stage divider is fully pipelined.
// Reset: rst (synchronous) clears all valid bits and loads step 1, offset 0, depth 16.
// The receiver cannot stall; results are never held.
module residual_quantize_reconstruct #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cfg_write,
  input  logic [rqr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rqr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             operation,
  input  logic [rqr_pkg::SAMPLE_W-1:0]     original_sample,
  input  logic [rqr_pkg::SAMPLE_W-1:0]     prediction_sample,
  input  logic [rqr_pkg::SAMPLE_W-1:0]     quantized_in,
  input  logic                             last_sample,
  output logic                             done,
  output logic [rqr_pkg::SAMPLE_W-1:0]     quantized_out,
  output logic [rqr_pkg::SAMPLE_W-1:0]     reconstructed_sample,
  output logic                             last_out
);
  import rqr_pkg::*;

  logic [STEP_W-1:0]   quant_step;
  logic [OFFSET_W-1:0] quant_offset;
  logic [DEPTH_W-1:0]  bit_depth;

  logic [STEP_W-1:0]   step_eff;
  logic [DEPTH_W-1:0]  depth_eff;
  logic [SAMPLE_W-1:0] sample_max;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      quant_step   <= STEP_W'(1);
      quant_offset <= '0;
      bit_depth    <= DEPTH_W'(16);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_QUANT_STEP:   quant_step   <= cfg_data[STEP_W-1:0];
        REG_QUANT_OFFSET: quant_offset <= cfg_data[OFFSET_W-1:0];
        REG_BIT_DEPTH:    bit_depth    <= cfg_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    step_eff = (quant_step == '0) ? STEP_W'(1) : quant_step;
    if (bit_depth == '0) begin
      depth_eff = DEPTH_W'(1);
    end else if (bit_depth > DEPTH_W'(SAMPLE_BITS)) begin
      depth_eff = DEPTH_W'(SAMPLE_BITS);
    end else begin
      depth_eff = bit_depth;
    end
    sample_max = SAMPLE_W'((17'(1) << depth_eff) - 17'(1));
  end

  // input stage
  logic                s0_valid;
  logic                s0_op;
  logic [SAMPLE_W-1:0] s0_orig;
  logic [SAMPLE_W-1:0] s0_pred;
  logic [SAMPLE_W-1:0] s0_qin;
  logic                s0_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
    s0_op   <= operation;
    s0_orig <= original_sample;
    s0_pred <= prediction_sample;
    s0_qin  <= quantized_in;
    s0_last <= last_sample;
  end

  // offset residual plus half step; negative means quotient clamps to zero
  logic signed [SUM_W-1:0] n_sum;
  logic                    s1_valid;
  logic                    s1_op;
  logic [SAMPLE_W-1:0]     s1_pred;
  logic [SAMPLE_W-1:0]     s1_qin;
  logic                    s1_last;
  logic [DIVIDEND_W-1:0]   s1_dividend;

  assign n_sum = $signed({4'b0, s0_orig}) - $signed({4'b0, s0_pred})
               + $signed({{(SUM_W-OFFSET_W){quant_offset[OFFSET_W-1]}}, quant_offset})
               + $signed({5'b0, step_eff[STEP_W-1:1]});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
    end
    s1_op       <= s0_op;
    s1_pred     <= s0_pred;
    s1_qin      <= s0_qin;
    s1_last     <= s0_last;
    s1_dividend <= n_sum[SUM_W-1] ? '0 : n_sum[DIVIDEND_W-1:0];
  end

  logic [DIVIDEND_W-1:0] quotient;

  rqr_divider u_divider (
    .clk      (clk),
    .divisor  (step_eff),
    .dividend (s1_dividend),
    .quotient (quotient)
  );

  // side data travels alongside the divider stages
  logic                dl_valid [DIV_STAGES];
  logic                dl_op    [DIV_STAGES];
  logic [SAMPLE_W-1:0] dl_pred  [DIV_STAGES];
  logic [SAMPLE_W-1:0] dl_qin   [DIV_STAGES];
  logic                dl_last  [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        dl_valid[i] <= 1'b0;
      end
    end else begin
      dl_valid[0] <= s1_valid;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dl_valid[i] <= dl_valid[i-1];
      end
    end
    dl_op[0]   <= s1_op;
    dl_pred[0] <= s1_pred;
    dl_qin[0]  <= s1_qin;
    dl_last[0] <= s1_last;
    for (int i = 1; i < DIV_STAGES; i++) begin
      dl_op[i]   <= dl_op[i-1];
      dl_pred[i] <= dl_pred[i-1];
      dl_qin[i]  <= dl_qin[i-1];
      dl_last[i] <= dl_last[i-1];
    end
  end

  // quantized value select and clamp
  logic                sq_valid;
  logic [SAMPLE_W-1:0] sq_q;
  logic [SAMPLE_W-1:0] sq_pred;
  logic                sq_last;
  logic [SAMPLE_W-1:0] q_enc;

  assign q_enc = (quotient > {2'b0, sample_max}) ? sample_max : quotient[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= dl_valid[DIV_STAGES-1];
    end
    sq_q    <= (dl_op[DIV_STAGES-1] == OP_DECODE) ? dl_qin[DIV_STAGES-1] : q_enc;
    sq_pred <= dl_pred[DIV_STAGES-1];
    sq_last <= dl_last[DIV_STAGES-1];
  end

  // dequantize
  logic                sm_valid;
  logic [PROD_W-1:0]   sm_prod;
  logic [SAMPLE_W-1:0] sm_q;
  logic [SAMPLE_W-1:0] sm_pred;
  logic                sm_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sm_valid <= 1'b0;
    end else begin
      sm_valid <= sq_valid;
    end
    sm_prod <= PROD_W'(sq_q) * PROD_W'(step_eff);
    sm_q    <= sq_q;
    sm_pred <= sq_pred;
    sm_last <= sq_last;
  end

  // reconstruction and output clip
  logic signed [REC_W-1:0] rec_sum;
  logic [SAMPLE_W-1:0]     rec_clip;

  assign rec_sum = $signed({3'b0, sm_prod}) + $signed({{(REC_W-SAMPLE_W){1'b0}}, sm_pred})
                 - $signed({{(REC_W-OFFSET_W){quant_offset[OFFSET_W-1]}}, quant_offset});

  always_comb begin
    if (rec_sum[REC_W-1]) begin
      rec_clip = '0;
    end else if (rec_sum > $signed({{(REC_W-SAMPLE_W){1'b0}}, sample_max})) begin
      rec_clip = sample_max;
    end else begin
      rec_clip = rec_sum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sm_valid;
    end
    quantized_out        <= sm_q;
    reconstructed_sample <= rec_clip;
    last_out             <= sm_last;
  end

endmodule

@@ test/residual_quantize_reconstruct_check.sv @@
// Checker for the residual quantizer: predicts each request's result and compares it.
`timescale 1ns / 1ps

module residual_quantize_reconstruct_check #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic                            cfg_write,
  input  logic [rqr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rqr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            operation,
  input  logic [rqr_pkg::SAMPLE_W-1:0]    original_sample,
  input  logic [rqr_pkg::SAMPLE_W-1:0]    prediction_sample,
  input  logic [rqr_pkg::SAMPLE_W-1:0]    quantized_in,
  input  logic                            last_sample,
  input  logic                            done,
  input  logic [rqr_pkg::SAMPLE_W-1:0]    quantized_out,
  input  logic [rqr_pkg::SAMPLE_W-1:0]    reconstructed_sample,
  input  logic                            last_out,
  output int                              fail_count,
  output int                              pending
);
  import rqr_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] quantized;
    logic [SAMPLE_W-1:0] recon;
    logic                last;
  } recon_t;

  recon_t                expected_recon_q[$];
  logic [STEP_W-1:0]     step_reg;
  logic [OFFSET_W-1:0]   offset_reg;
  logic [DEPTH_W-1:0]    depth_reg;

  function automatic longint clamp_sample(longint v, longint hi);
    if (v < 0) return 0;
    return (v > hi) ? hi : v;
  endfunction

  function automatic recon_t quantize_reconstruct(op_t op, logic [SAMPLE_W-1:0] orig,
                                                  logic [SAMPLE_W-1:0] pred,
                                                  logic [SAMPLE_W-1:0] qin, logic last);
    longint step;
    longint off;
    longint maxv;
    longint num;
    longint den;
    longint q;
    longint rec;
    int     bits;
    recon_t res;
    step = (step_reg == '0) ? 1 : longint'(step_reg);
    off  = longint'($signed(offset_reg));
    bits = int'(depth_reg);
    if (bits < 1) bits = 1;
    if (bits > SAMPLE_BITS) bits = SAMPLE_BITS;
    maxv = (longint'(1) << bits) - 1;
    if (op == OP_ENCODE) begin
      num = 2 * (longint'(orig) - longint'(pred) + off) + step;
      den = 2 * step;
      // floor division, rounds toward minus infinity
      q = (num >= 0) ? num / den : -((-num + den - 1) / den);
      q = clamp_sample(q, maxv);
    end else begin
      q = longint'(qin);
    end
    rec = clamp_sample(longint'(pred) + q * step - off, maxv);
    res.quantized = q[SAMPLE_W-1:0];
    res.recon     = rec[SAMPLE_W-1:0];
    res.last      = last;
    return res;
  endfunction

  always @(posedge clk) begin
    recon_t want;
    int     errs;
    errs = 0;
    if (rst) begin
      step_reg   <= STEP_W'(1);
      offset_reg <= '0;
      depth_reg  <= DEPTH_W'(16);
      expected_recon_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_QUANT_STEP:   step_reg   <= cfg_data[STEP_W-1:0];
          REG_QUANT_OFFSET: offset_reg <= cfg_data[OFFSET_W-1:0];
          REG_BIT_DEPTH:    depth_reg  <= cfg_data[DEPTH_W-1:0];
          default: ;
        endcase
      end
      if (done) begin
        if (expected_recon_q.size() == 0) begin
          $display("%0t unexpected result: quantized %h recon %h last %b", $time,
                   quantized_out, reconstructed_sample, last_out);
          errs++;
        end else begin
          want = expected_recon_q.pop_front();
          if (quantized_out !== want.quantized) begin
            $display("%0t quantized_out expected %h actual %h", $time, want.quantized,
                     quantized_out);
            errs++;
          end
          if (reconstructed_sample !== want.recon) begin
            $display("%0t reconstructed_sample expected %h actual %h", $time, want.recon,
                     reconstructed_sample);
            errs++;
          end
          if (last_out !== want.last) begin
            $display("%0t last_out expected %b actual %b", $time, want.last, last_out);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        expected_recon_q.insert(expected_recon_q.size(),
                                quantize_reconstruct(op_t'(operation), original_sample,
                                prediction_sample, quantized_in, last_sample));
      end
      fail_count <= fail_count + errs;
      pending    <= expected_recon_q.size();
    end
  end

endmodule

@@ test/residual_quantize_reconstruct_test.sv @@
// Testbench top for the residual quantizer: stimulus, reset, clock and verdict.
`timescale 1ns / 1ps

module residual_quantize_reconstruct_test;
  import rqr_pkg::*;

  localparam int SAMPLE_BITS = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   operation;
  logic [SAMPLE_W-1:0]    original_sample;
  logic [SAMPLE_W-1:0]    prediction_sample;
  logic [SAMPLE_W-1:0]    quantized_in;
  logic                   last_sample;
  logic                   done;
  logic [SAMPLE_W-1:0]    quantized_out;
  logic [SAMPLE_W-1:0]    reconstructed_sample;
  logic                   last_out;
  int                     fail_count;
  int                     pending;
  int                     idle_pct;

  residual_quantize_reconstruct #(.SAMPLE_BITS(SAMPLE_BITS)) dut (.*);

  residual_quantize_reconstruct_check #(.SAMPLE_BITS(SAMPLE_BITS)) scoreboard (
    .clk, .rst, .start, .busy, .cfg_write, .cfg_index, .cfg_data, .operation,
    .original_sample, .prediction_sample, .quantized_in, .last_sample, .done,
    .quantized_out, .reconstructed_sample, .last_out, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send(op_t op, logic [SAMPLE_W-1:0] orig, logic [SAMPLE_W-1:0] pred,
                      logic [SAMPLE_W-1:0] qin, logic last);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start             <= 1'b1;
    operation         <= op;
    original_sample   <= orig;
    prediction_sample <= pred;
    quantized_in      <= qin;
    last_sample       <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] step, logic [CFG_DATA_W-1:0] off,
                           logic [CFG_DATA_W-1:0] depth);
    wait_idle();
    write_reg(REG_QUANT_STEP, step);
    write_reg(REG_QUANT_OFFSET, off);
    write_reg(REG_BIT_DEPTH, depth);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_W'($urandom_range(31));
      3:       return SAMPLE_W'(16'hFFFF - $urandom_range(31));
      default: return SAMPLE_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic random_config();
    logic [CFG_DATA_W-1:0] step;
    logic [CFG_DATA_W-1:0] off;
    logic [CFG_DATA_W-1:0] depth;
    case ($urandom_range(4))
      0:       step = CFG_DATA_W'(0);
      1:       step = CFG_DATA_W'(1);
      2:       step = CFG_DATA_W'(16'hFFFF);
      3:       step = CFG_DATA_W'($urandom_range(1, 16));
      default: step = CFG_DATA_W'($urandom_range(16'hFFFF));
    endcase
    step[CFG_DATA_W-1] = 1'($urandom_range(1));
    case ($urandom_range(4))
      0:       off = 17'h10000;
      1:       off = 17'h0FFFF;
      2:       off = '0;
      3:       off = CFG_DATA_W'($urandom_range(128)) - CFG_DATA_W'(64);
      default: off = CFG_DATA_W'($urandom_range(17'h1FFFF));
    endcase
    case ($urandom_range(4))
      0:       depth = CFG_DATA_W'($urandom_range(1));
      1:       depth = CFG_DATA_W'(8);
      2:       depth = CFG_DATA_W'(16);
      3:       depth = CFG_DATA_W'($urandom_range(17, 31));
      default: depth = CFG_DATA_W'($urandom_range(31));
    endcase
    depth[CFG_DATA_W-1:DEPTH_W] = (CFG_DATA_W-DEPTH_W)'($urandom_range(12'hFFF));
    configure(step, off, depth);
    if ($urandom_range(3) == 0) begin
      write_reg(REG_NONE, CFG_DATA_W'($urandom_range(17'h1FFFF)));
      cfg_write <= 1'b0;
    end
  endtask

  task automatic send_random();
    logic [SAMPLE_W-1:0] pred;
    logic [SAMPLE_W-1:0] orig;
    pred = pick_sample();
    // residuals near zero hit the rounding boundaries
    if ($urandom_range(2) == 0) orig = pred + SAMPLE_W'($urandom_range(64)) - SAMPLE_W'(32);
    else orig = pick_sample();
    send(op_t'($urandom_range(1)), orig, pred, pick_sample(), 1'($urandom_range(1)));
  endtask

  initial begin
    rst               <= 1'b1;
    start             <= 1'b0;
    cfg_write         <= 1'b0;
    cfg_index         <= REG_QUANT_STEP;
    cfg_data          <= '0;
    operation         <= OP_ENCODE;
    original_sample   <= '0;
    prediction_sample <= '0;
    quantized_in      <= '0;
    last_sample       <= 1'b0;
    idle_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings
    send(OP_ENCODE, 16'hFFFF, 16'h0000, 16'h0000, 1'b1);
    send(OP_ENCODE, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
    send(OP_DECODE, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1);
    send(OP_DECODE, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    send(OP_ENCODE, 16'd1000, 16'd999, 16'h0000, 1'b0);

    // zero step, zero depth, most negative offset
    configure(17'h00000, 17'h10000, 17'h00000);
    send(OP_ENCODE, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send(OP_ENCODE, 16'hFFFF, 16'h0000, 16'h5555, 1'b1);
    send(OP_DECODE, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
    send(OP_DECODE, 16'hAAAA, 16'h0001, 16'h0001, 1'b1);

    // widest step, largest offset, depth above sample width
    configure(17'h0FFFF, 17'h0FFFF, 17'h0001F);
    send(OP_ENCODE, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    send(OP_ENCODE, 16'h0000, 16'hFFFF, 16'h0000, 1'b1);
    send(OP_DECODE, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
    send(OP_DECODE, 16'hFFFF, 16'h0000, 16'h0000, 1'b1);
    send(OP_ENCODE, 16'h7FFF, 16'h0000, 16'h0000, 1'b0);

    // rounding half up around zero, decode value above range
    configure(17'd4, 17'd0, 17'd8);
    send(OP_ENCODE, 16'd102, 16'd100, 16'h0000, 1'b0);
    send(OP_ENCODE, 16'd98, 16'd100, 16'h0000, 1'b0);
    send(OP_ENCODE, 16'd101, 16'd100, 16'h0000, 1'b0);
    send(OP_ENCODE, 16'd97, 16'd100, 16'h0000, 1'b1);
    send(OP_DECODE, 16'h0000, 16'd100, 16'd70, 1'b0);
    send(OP_DECODE, 16'h0000, 16'd10, 16'hFFFF, 1'b1);

    // write to an unknown index must leave the settings alone
    wait_idle();
    write_reg(REG_NONE, 17'h1FFFF);
    cfg_write <= 1'b0;
    send(OP_ENCODE, 16'd103, 16'd100, 16'h0000, 1'b0);
    send(OP_DECODE, 16'h0000, 16'd100, 16'd3, 1'b1);

    for (int seg = 0; seg < 9; seg++) begin
      idle_pct = (seg < 3) ? 29 : (seg < 6) ? 45 : 0;
      random_config();
      repeat (50) send_random();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
